### rtl/homogeneous_vertex_transform_unit_defines.svh
// Assertion macros for the homogeneous vertex transform unit.
// Used by the port checker; needs clk and arst_n in scope.
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_DEFINES_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent from the next cycle on
`define HVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hvt_pkg.sv
// Shared constants, types and helpers of the homogeneous vertex transform unit.
// No dependencies.
package hvt_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IO_W        = 32;
	localparam int PAIR_W      = 64;
	localparam int HALF_W      = 32;
	localparam int NUM_PAIRS   = 8;
	localparam int PAIR_IDX_W  = $clog2(NUM_PAIRS);
	localparam int CFG_IDX_W   = 8;
	localparam int NUM_ROWS    = 4;
	localparam int NUM_LANES   = 3;
	localparam int PROD_W      = 2 * COORD_WIDTH;
	localparam int ACC_W       = 2 * COORD_WIDTH + 3;
	localparam int MAG_W       = ACC_W;
	localparam int QUO_W       = COORD_WIDTH;
	localparam int REM_W       = MAG_W + QUO_W + 1;
	localparam int Q_DEPTH     = 2;
	localparam int Q_PTR_W     = $clog2(Q_DEPTH);
	localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
	// start accepted to done sampled high
	localparam int LATENCY     = QUO_W + 7;

	localparam logic [PAIR_W-1:0] ONE_LO = PAIR_W'(1) << FRAC_BITS;
	localparam logic [PAIR_W-1:0] ONE_HI = PAIR_W'(1) << (HALF_W + FRAC_BITS);
	localparam logic [PAIR_W-1:0] COEF_RESET [NUM_PAIRS] = '{
		ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
	};

	typedef enum logic {
		MODE_POINT  = 1'b0,
		MODE_VECTOR = 1'b1
	} mode_t;

	// one transformed row set on its way to the divider
	typedef struct packed {
		logic                            is_point;
		logic [NUM_ROWS-1:0][ACC_W-1:0]  acc;
	} q_item_t;

	function automatic logic [MAG_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
		abs_acc = v[ACC_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

endpackage

### rtl/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous vertex transform unit: 4x4 Q16.16 transform
// with perspective divide. Depends on hvt_pkg, hvt_front, hvt_queue, hvt_back.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  command   | start / busy          | mode, in_x, in_y, in_z
//  result    | done (one-cycle)      | out_x, out_y, out_z, w_was_zero, saturated
//  config    | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One vertex per clock sustained; from start to done each passes through the
// capture, multiply and add stages (3), queue (1), divisor selection (1),
// divider set-up (1), 32 divider stages (one quotient bit each) and the
// result register (1). The queue drains every cycle, so busy stays low.
// Reset puts the identity matrix in the coefficient registers and empties
// the pipeline. Results cannot be held off; done marks each for one cycle.
module homogeneous_vertex_transform_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                mode,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_x,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_y,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_z,
	output logic                                done,
	output logic signed [hvt_pkg::IO_W-1:0]     out_x,
	output logic signed [hvt_pkg::IO_W-1:0]     out_y,
	output logic signed [hvt_pkg::IO_W-1:0]     out_z,
	output logic                                w_was_zero,
	output logic                                saturated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hvt_pkg::PAIR_W-1:0]          cfg_data
);

	logic             push, pop, q_full;
	hvt_pkg::q_item_t push_item, pop_item;

	assign cfg_ready = 1'b1;
	assign busy      = q_full;

	hvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_item (push_item)
	);

	hvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full)
	);

	hvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pop),
		.in_item    (pop_item),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.w_was_zero (w_was_zero),
		.saturated  (saturated)
	);

endmodule

### rtl/hvt_front.sv
// Front end: coefficient registers, item capture and matrix multiply-accumulate.
// Depends on hvt_pkg.
module hvt_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                mode,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_x,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_y,
	input  logic signed [hvt_pkg::IO_W-1:0]     in_z,
	input  logic                                cfg_wr,
	input  logic [hvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hvt_pkg::PAIR_W-1:0]          cfg_data,
	output logic                                push,
	output hvt_pkg::q_item_t                    push_item
);

	localparam int CW = hvt_pkg::COORD_WIDTH;

	logic [hvt_pkg::PAIR_W-1:0] coef_q [hvt_pkg::NUM_PAIRS];
	logic signed [CW-1:0] m [16];

	logic                 valid_s1, point_s1;
	logic signed [CW-1:0] crd_s1 [3];

	logic                             valid_s2, point_s2;
	logic signed [hvt_pkg::PROD_W-1:0] prod_s2 [hvt_pkg::NUM_ROWS][3];
	logic signed [CW-1:0]             trans_s2 [hvt_pkg::NUM_ROWS];

	logic                             valid_s3, point_s3;
	logic signed [hvt_pkg::ACC_W-1:0] part_a_s3 [hvt_pkg::NUM_ROWS];
	logic signed [hvt_pkg::ACC_W-1:0] part_b_s3 [hvt_pkg::NUM_ROWS];

	// coefficient registers, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < hvt_pkg::NUM_PAIRS; p++) coef_q[p] <= hvt_pkg::COEF_RESET[p];
		end else if (cfg_wr && (cfg_index < hvt_pkg::CFG_IDX_W'(hvt_pkg::NUM_PAIRS))) begin
			coef_q[cfg_index[hvt_pkg::PAIR_IDX_W-1:0]] <= cfg_data;
		end
	end

	// entry i: low half of pair i/2 when even, high half when odd
	for (genvar i = 0; i < 16; i++) begin : g_coef
		assign m[i] = $signed(coef_q[i / 2][(i % 2) * hvt_pkg::HALF_W +: CW]);
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// s1: capture, low bits of each coordinate only
	always_ff @(posedge clk) begin
		point_s1  <= (mode == hvt_pkg::MODE_POINT);
		crd_s1[0] <= $signed(in_x[CW-1:0]);
		crd_s1[1] <= $signed(in_y[CW-1:0]);
		crd_s1[2] <= $signed(in_z[CW-1:0]);
	end

	// s2: one product per row and column
	always_ff @(posedge clk) begin
		point_s2 <= point_s1;
		for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
			for (int c = 0; c < 3; c++)
				prod_s2[r][c] <= hvt_pkg::PROD_W'(m[r + 4 * c]) * hvt_pkg::PROD_W'(crd_s1[c]);
			trans_s2[r] <= point_s1 ? m[12 + r] : '0;
		end
	end

	// s3: two partial sums per row
	always_ff @(posedge clk) begin
		point_s3 <= point_s2;
		for (int r = 0; r < hvt_pkg::NUM_ROWS; r++) begin
			part_a_s3[r] <= hvt_pkg::ACC_W'(prod_s2[r][0]) + hvt_pkg::ACC_W'(prod_s2[r][1]);
			part_b_s3[r] <= hvt_pkg::ACC_W'(prod_s2[r][2])
				+ (hvt_pkg::ACC_W'(trans_s2[r]) <<< hvt_pkg::FRAC_BITS);
		end
	end

	// final sum straight into the queue
	always_comb begin
		push_item.is_point = point_s3;
		for (int r = 0; r < hvt_pkg::NUM_ROWS; r++)
			push_item.acc[r] = part_a_s3[r] + part_b_s3[r];
	end
	assign push = valid_s3;

endmodule

### rtl/hvt_queue.sv
// Short queue between the multiply front end and the divide back end.
// Depends on hvt_pkg.
module hvt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  hvt_pkg::q_item_t push_item,
	output logic             pop,
	output hvt_pkg::q_item_t pop_item,
	output logic             full
);

	hvt_pkg::q_item_t              mem_q [hvt_pkg::Q_DEPTH];
	logic [hvt_pkg::Q_PTR_W-1:0]   wr_q, rd_q;
	logic [hvt_pkg::Q_CNT_W-1:0]   cnt_q;

	// back end takes an entry whenever one is there
	assign pop      = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];
	assign full     = (cnt_q == hvt_pkg::Q_CNT_W'(hvt_pkg::Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/hvt_back.sv
// Back end: divisor selection, pipelined restoring divide and saturation.
// Depends on hvt_pkg.
module hvt_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  hvt_pkg::q_item_t                 in_item,
	output logic                             done,
	output logic signed [hvt_pkg::IO_W-1:0]  out_x,
	output logic signed [hvt_pkg::IO_W-1:0]  out_y,
	output logic signed [hvt_pkg::IO_W-1:0]  out_z,
	output logic                             w_was_zero,
	output logic                             saturated
);

	localparam int NL = hvt_pkg::NUM_LANES;
	localparam int QW = hvt_pkg::QUO_W;
	localparam int RW = hvt_pkg::REM_W;
	localparam int MW = hvt_pkg::MAG_W;
	localparam int CW = hvt_pkg::COORD_WIDTH;
	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (CW - 1));

	logic           valid_s1, wz_s1;
	logic [MW-1:0]  dmag_s1;
	logic [MW-1:0]  mag_s1 [NL];
	logic [NL-1:0]  neg_s1;

	// divider stage arrays, index 0 is the set-up stage
	logic           dv_vld_s [QW+1];
	logic           dv_wz_s  [QW+1];
	logic [MW-1:0]  dv_dmag_s [QW+1];
	logic [RW-1:0]  dv_rem_s [QW+1][NL];
	logic [QW-1:0]  dv_quo_s [QW+1][NL];
	logic [NL-1:0]  dv_neg_s [QW+1];
	logic [NL-1:0]  dv_ovf_s [QW+1];

	logic                 done_q, wz_q, sat_q;
	logic signed [hvt_pkg::IO_W-1:0] res_q [NL];

	logic           w_zero, d_neg;
	logic [MW-1:0]  d_mag;

	// divisor: |w| in point mode, 1.0 in vector mode or when w is zero
	always_comb begin
		w_zero = in_item.is_point && (in_item.acc[3] == '0);
		d_neg  = in_item.is_point && !w_zero && in_item.acc[3][hvt_pkg::ACC_W-1];
		d_mag  = (in_item.is_point && !w_zero) ? hvt_pkg::abs_acc(in_item.acc[3])
			: (MW'(1) << (2 * hvt_pkg::FRAC_BITS));
	end

	always_ff @(posedge clk) begin
		wz_s1   <= w_zero;
		dmag_s1 <= d_mag;
		for (int l = 0; l < NL; l++) begin
			mag_s1[l] <= hvt_pkg::abs_acc(in_item.acc[l]);
			neg_s1[l] <= in_item.acc[l][hvt_pkg::ACC_W-1] ^ d_neg;
		end
	end

	// set-up: numerator and quotient overflow check
	always_ff @(posedge clk) begin
		dv_wz_s[0]   <= wz_s1;
		dv_dmag_s[0] <= dmag_s1;
		dv_neg_s[0]  <= neg_s1;
		for (int l = 0; l < NL; l++) begin
			dv_rem_s[0][l] <= RW'(mag_s1[l]) << hvt_pkg::FRAC_BITS;
			dv_quo_s[0][l] <= '0;
			dv_ovf_s[0][l] <= (RW'(mag_s1[l]) << hvt_pkg::FRAC_BITS) >= (RW'(dmag_s1) << QW);
		end
	end

	// valid bits of the divisor selection and set-up stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else begin
			valid_s1    <= in_valid;
			dv_vld_s[0] <= valid_s1;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int SH = QW - 1 - k;
		logic [RW-1:0] trial;
		assign trial = RW'(dv_dmag_s[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s[k+1] <= 1'b0;
			else dv_vld_s[k+1] <= dv_vld_s[k];
		end

		always_ff @(posedge clk) begin
			dv_wz_s[k+1]   <= dv_wz_s[k];
			dv_dmag_s[k+1] <= dv_dmag_s[k];
			dv_neg_s[k+1]  <= dv_neg_s[k];
			dv_ovf_s[k+1]  <= dv_ovf_s[k];
			for (int l = 0; l < NL; l++) begin
				if (dv_rem_s[k][l] >= trial) begin
					dv_rem_s[k+1][l] <= dv_rem_s[k][l] - trial;
					dv_quo_s[k+1][l] <= {dv_quo_s[k][l][QW-2:0], 1'b1};
				end else begin
					dv_rem_s[k+1][l] <= dv_rem_s[k][l];
					dv_quo_s[k+1][l] <= {dv_quo_s[k][l][QW-2:0], 1'b0};
				end
			end
		end
	end

	// saturate, apply sign, register the result
	logic [NL-1:0]  lane_sat;
	logic [QW-1:0]  lane_mag [NL];
	logic [QW-1:0]  lane_lim [NL];
	logic [CW-1:0]  lane_res [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			lane_lim[l] = dv_neg_s[QW][l] ? LIM_NEG : LIM_POS;
			lane_sat[l] = dv_ovf_s[QW][l] || (dv_quo_s[QW][l] > lane_lim[l]);
			lane_mag[l] = lane_sat[l] ? lane_lim[l] : dv_quo_s[QW][l];
			lane_res[l] = dv_neg_s[QW][l] ? CW'(-lane_mag[l]) : CW'(lane_mag[l]);
		end
	end

	always_ff @(posedge clk) begin
		wz_q  <= dv_wz_s[QW];
		sat_q <= |lane_sat;
		for (int l = 0; l < NL; l++) res_q[l] <= hvt_pkg::IO_W'($signed(lane_res[l]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dv_vld_s[QW];
	end

	assign done       = done_q;
	assign out_x      = res_q[0];
	assign out_y      = res_q[1];
	assign out_z      = res_q[2];
	assign w_was_zero = wz_q;
	assign saturated  = sat_q;

endmodule

### rtl/hvt_checker.sv
// Port checker for the homogeneous vertex transform unit, bound to the top.
// Depends on hvt_pkg and the assertion macro header.
`include "homogeneous_vertex_transform_unit_defines.svh"

module hvt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic mode,
	input logic done,
	input logic w_was_zero
);

	logic accepted;
	assign accepted = start && !busy && arst_n;

	// every accepted vertex comes out after the fixed latency
	`HVT_ASSERT_NEXT(a_done_follows, accepted, ##(hvt_pkg::LATENCY - 1) done, "accepted item lost")
	// no result without a matching transfer in
	`HVT_ASSERT_NOW(a_done_has_cause, done, $past(accepted, hvt_pkg::LATENCY), "spurious result")
	// zero w flag only for point mode items
	`HVT_ASSERT_NOW(a_wz_point_only, done && w_was_zero,
		$past(mode == hvt_pkg::MODE_POINT, hvt_pkg::LATENCY), "w flag on vector item")

endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.mode       (mode),
	.done       (done),
	.w_was_zero (w_was_zero)
);
